// ----- hdl/crv_pkg.sv -----
// ----------------------------------------------------------------------------
// crv_pkg
// Types and constants shared by the cell repulsion velocity block.
// ----------------------------------------------------------------------------
package crv_pkg;

  localparam int POS_W = 32;
  localparam int RAD_W = 24;
  localparam int ID_W  = 16;
  localparam int RF_W  = 16;
  localparam int REP_W = 24;
  localparam int VEL_W = 40;
  localparam int CNT_W = 8;
  localparam int CFG_W = 24;

  localparam logic CFG_REST_FACTOR = 1'b0;
  localparam logic CFG_REPULSION   = 1'b1;

  localparam logic [RF_W-1:0]  REST_FACTOR_RST = 16'd4096;
  localparam logic [REP_W-1:0] REPULSION_RST   = 24'd655360;

  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic [CNT_W-1:0]        CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic                    nbr_present;
    logic [ID_W-1:0]         self_id;
    logic [ID_W-1:0]         nbr_id;
    logic signed [POS_W-1:0] self_x;
    logic signed [POS_W-1:0] self_y;
    logic [RAD_W-1:0]        self_radius;
    logic signed [POS_W-1:0] nbr_x;
    logic signed [POS_W-1:0] nbr_y;
    logic [RAD_W-1:0]        nbr_radius;
    logic                    last_nbr;
  } in_item_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic [CNT_W-1:0]        overlap_count;
  } out_item_t;

endpackage

// ----- hdl/crv_mul.sv -----
// ----------------------------------------------------------------------------
// crv_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module crv_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

// ----- hdl/cell_repulsion_velocity.sv -----
// ----------------------------------------------------------------------------
// cell_repulsion_velocity
// Quadratic overlap repulsion: accumulates x velocity of one cell over its
// candidate neighbours, emitting velocity and overlap count on the last one.
// ----------------------------------------------------------------------------
// Sequencing: an item that carries no usable neighbour goes from S_ABS to
// S_FIN; a checked one also runs the shared multiplier sequence (S_SQX to
// S_CMP) and S_DEC; an overlapping one adds the one-bit-per-cycle restoring
// divider (S_DIV), S_T2, S_MAG and S_ACC. No new item is taken before the
// last is through. The result, registered in S_FIN, is held until taken.
// Reset (rst, synchronous): accumulators cleared, registers to defaults.
// ----------------------------------------------------------------------------
module cell_repulsion_velocity #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  crv_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output crv_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [crv_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CNT_DIV_W = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;
  localparam int RS_W      = crv_pkg::RAD_W + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ABS  = 4'd1;
  localparam logic [3:0] S_SQX  = 4'd2;
  localparam logic [3:0] S_SQY  = 4'd3;
  localparam logic [3:0] S_P    = 4'd4;
  localparam logic [3:0] S_PLD  = 4'd5;
  localparam logic [3:0] S_PLL  = 4'd6;
  localparam logic [3:0] S_PLH  = 4'd7;
  localparam logic [3:0] S_PHH  = 4'd8;
  localparam logic [3:0] S_CMP  = 4'd9;
  localparam logic [3:0] S_DEC  = 4'd10;
  localparam logic [3:0] S_DIV  = 4'd11;
  localparam logic [3:0] S_T2   = 4'd12;
  localparam logic [3:0] S_MAG  = 4'd13;
  localparam logic [3:0] S_ACC  = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  logic [3:0] state;

  logic [crv_pkg::RF_W-1:0]  rest_factor;
  logic [crv_pkg::REP_W-1:0] repulsion_strength;

  logic signed [crv_pkg::VEL_W-1:0] vel_accum;
  logic [crv_pkg::CNT_W-1:0]        count_accum;

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [31:0]        adx;
  logic [31:0]        ady;
  logic [RS_W-1:0]    rsum;
  logic               active;
  logic               last;
  logic [64:0]        dsum;
  logic [40:0]        p;
  logic [81:0]        acc;
  logic [RS_W-1:0]    rem;
  logic [FRAC_BITS-1:0] quo;
  logic [CNT_DIV_W-1:0] div_cnt;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  logic               in_xfer;
  logic               out_free;
  logic [88:0]        dist_sh;
  logic [88:0]        acc_ext;
  logic               overlap;
  logic [RS_W:0]      rem2;
  logic               rem_ge;
  logic [crv_pkg::REP_W-1:0]        mag;
  logic signed [crv_pkg::VEL_W:0]   vel_sum;
  logic signed [crv_pkg::VEL_W-1:0] vel_sat;

  crv_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQX: begin
        mul_a = adx;
        mul_b = adx;
      end
      S_SQY: begin
        mul_a = ady;
        mul_b = ady;
      end
      S_P: begin
        mul_a = 32'(rsum);
        mul_b = 32'(rest_factor);
      end
      S_PLL: begin
        mul_a = p[31:0];
        mul_b = p[31:0];
      end
      S_PLH: begin
        mul_a = p[31:0];
        mul_b = 32'(p[40:32]);
      end
      S_PHH: begin
        mul_a = 32'(p[40:32]);
        mul_b = 32'(p[40:32]);
      end
      S_T2: begin
        mul_a = 32'(quo);
        mul_b = 32'(quo);
      end
      S_MAG: begin
        mul_a = 32'(repulsion_strength);
        mul_b = 32'(prod[FRAC_BITS +: FRAC_BITS]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // admission: dist^2 * 2^24 <= (rsum * rest_factor)^2
  assign dist_sh = {dsum, 24'b0};
  assign acc_ext = {7'b0, acc};
  assign overlap = (dist_sh <= acc_ext) && (adx != '0) && (adx < 32'(rsum));

  assign rem2   = {rem, 1'b0};
  assign rem_ge = (rem2 >= {1'b0, rsum});

  assign mag     = prod[FRAC_BITS +: crv_pkg::REP_W];
  assign vel_sum = dx[32]
                 ? {vel_accum[crv_pkg::VEL_W-1], vel_accum} + $signed({17'b0, mag})
                 : {vel_accum[crv_pkg::VEL_W-1], vel_accum} - $signed({17'b0, mag});

  always_comb begin
    if (vel_sum[crv_pkg::VEL_W] != vel_sum[crv_pkg::VEL_W-1]) begin
      vel_sat = vel_sum[crv_pkg::VEL_W] ? crv_pkg::VEL_MIN : crv_pkg::VEL_MAX;
    end else begin
      vel_sat = vel_sum[crv_pkg::VEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_factor        <= crv_pkg::REST_FACTOR_RST;
      repulsion_strength <= crv_pkg::REPULSION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        crv_pkg::CFG_REST_FACTOR: rest_factor        <= cfg_data[crv_pkg::RF_W-1:0];
        crv_pkg::CFG_REPULSION:   repulsion_strength <= cfg_data[crv_pkg::REP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      vel_accum   <= '0;
      count_accum <= '0;
    end else begin
      if (out_valid && !out_stall && !(state == S_FIN && last)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_ABS;
          end
        end
        S_ABS: begin
          state <= active ? S_SQX : S_FIN;
        end
        S_SQX: state <= S_SQY;
        S_SQY: state <= S_P;
        S_P:   state <= S_PLD;
        S_PLD: state <= S_PLL;
        S_PLL: state <= S_PLH;
        S_PLH: state <= S_PHH;
        S_PHH: state <= S_CMP;
        S_CMP: state <= S_DEC;
        S_DEC: begin
          state <= overlap ? S_DIV : S_FIN;
        end
        S_DIV: begin
          if (div_cnt == CNT_DIV_W'(FRAC_BITS - 1)) begin
            state <= S_T2;
          end
        end
        S_T2:  state <= S_MAG;
        S_MAG: state <= S_ACC;
        S_ACC: begin
          vel_accum <= vel_sat;
          if (count_accum != crv_pkg::CNT_MAX) begin
            count_accum <= count_accum + 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!last) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid   <= 1'b1;
            vel_accum   <= '0;
            count_accum <= '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          dx     <= {in_item.nbr_x[31], in_item.nbr_x} - {in_item.self_x[31], in_item.self_x};
          dy     <= {in_item.nbr_y[31], in_item.nbr_y} - {in_item.self_y[31], in_item.self_y};
          rsum   <= {1'b0, in_item.self_radius} + {1'b0, in_item.nbr_radius};
          active <= in_item.nbr_present && (in_item.self_id != in_item.nbr_id);
          last   <= in_item.last_nbr;
        end
      end
      S_ABS: begin
        adx <= dx[32] ? 32'(-dx) : dx[31:0];
        ady <= dy[32] ? 32'(-dy) : dy[31:0];
      end
      S_SQY: dsum <= {1'b0, prod};
      S_P:   dsum <= dsum + {1'b0, prod};
      S_PLD: p <= prod[40:0];
      S_PLH: acc <= {18'b0, prod};
      S_PHH: acc <= acc + 82'({prod, 33'b0});
      S_CMP: acc <= acc + 82'({prod, 64'b0});
      S_DEC: begin
        rem     <= rsum - adx[RS_W-1:0];
        div_cnt <= '0;
      end
      S_DIV: begin
        rem     <= rem_ge ? RS_W'(rem2 - {1'b0, rsum}) : rem2[RS_W-1:0];
        quo     <= {quo[FRAC_BITS-2:0], rem_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      S_FIN: begin
        if (last && out_free) begin
          out_item.vel_x         <= vel_accum;
          out_item.overlap_count <= count_accum;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- verif/tb_cell_repulsion_velocity.sv -----
// ----------------------------------------------------------------------------
// tb_cell_repulsion_velocity
// Self-checking bench for the cell repulsion velocity block. A directed set
// of edge cases is followed by random neighbour runs under several register
// settings and idle patterns, and then by one long run that drives the
// overlap count into its limit. Each accepted transfer goes through a
// bit-exact predictor. Each result transfer is compared field by field with
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb_cell_repulsion_velocity;

  localparam int     FRAC        = 16;
  localparam int     DRAIN       = 64;
  localparam int     HOLD_CYCLES = 600;
  localparam int     SAT_RUN     = 300;
  localparam int     ONE         = 1 << FRAC;
  localparam longint CYCLE_LIMIT = 6_000_000;
  localparam int     CFG_W       = crv_pkg::CFG_W;
  localparam int     RF_W        = crv_pkg::RF_W;
  localparam int     REP_W       = crv_pkg::REP_W;
  localparam int     ID_W        = crv_pkg::ID_W;
  localparam int     RAD_W       = crv_pkg::RAD_W;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  crv_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  crv_pkg::out_item_t out_item;
  logic               cfg_we    = 1'b0;
  logic               cfg_index = crv_pkg::CFG_REST_FACTOR;
  logic [CFG_W-1:0]   cfg_data  = '0;

  crv_pkg::in_item_t  pend_q[$];
  crv_pkg::out_item_t vel_expect_q[$];
  logic [RF_W-1:0]    rf_reg  = crv_pkg::REST_FACTOR_RST;
  logic [REP_W-1:0]   rep_reg = crv_pkg::REPULSION_RST;
  longint             vel_acc = 0;
  int                 cnt_acc = 0;
  int                 send_idle = 0;
  int                 recv_idle = 0;
  bit                 hold_arm = 1'b0;
  bit                 hold_off = 1'b0;
  longint             cycles = 0;
  int                 errors = 0;
  int                 n_in = 0;
  int                 n_out = 0;
  int                 n_wr = 0;

  cell_repulsion_velocity #(.FRAC_BITS(FRAC)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("FAIL");
    $finish;
  end

  function automatic void report_mismatch(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void add_pending(input crv_pkg::in_item_t it);
    pend_q.insert(pend_q.size(), it);
  endfunction

  // Accumulates one neighbour and queues the totals when the run closes.
  function automatic void repel_predict(input crv_pkg::in_item_t it);
    longint             dx, dy, step, v;
    logic [63:0]        adx, ady, rsum, frac_t, frac_t2;
    logic [127:0]       dist_sq, reach;
    crv_pkg::out_item_t res;
    if (it.nbr_present && it.self_id != it.nbr_id) begin
      dx = longint'($signed(it.nbr_x)) - longint'($signed(it.self_x));
      dy = longint'($signed(it.nbr_y)) - longint'($signed(it.self_y));
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      rsum = 64'(it.self_radius) + 64'(it.nbr_radius);
      dist_sq = (128'(adx) * 128'(adx) + 128'(ady) * 128'(ady)) << 24;
      reach = 128'(rsum) * 128'(rf_reg);
      if (dist_sq <= reach * reach && adx != 0 && adx < rsum) begin
        frac_t  = ((rsum - adx) << FRAC) / rsum;
        frac_t2 = (frac_t * frac_t) >> FRAC;
        step = longint'((64'(rep_reg) * frac_t2) >> FRAC);
        v = (dx > 0) ? vel_acc - step : vel_acc + step;
        if (v > longint'(crv_pkg::VEL_MAX)) v = longint'(crv_pkg::VEL_MAX);
        if (v < longint'(crv_pkg::VEL_MIN)) v = longint'(crv_pkg::VEL_MIN);
        vel_acc = v;
        if (cnt_acc < int'(crv_pkg::CNT_MAX)) cnt_acc++;
      end
    end
    if (it.last_nbr) begin
      res.vel_x = vel_acc[crv_pkg::VEL_W-1:0];
      res.overlap_count = cnt_acc[crv_pkg::CNT_W-1:0];
      vel_expect_q.insert(vel_expect_q.size(), res);
      vel_acc = 0;
      cnt_acc = 0;
    end
  endfunction

  function automatic crv_pkg::in_item_t mk_item(input int present, input int sid,
                                                input int nid, input int sx, input int sy,
                                                input int sr, input int nx, input int ny,
                                                input int nr, input int last);
    crv_pkg::in_item_t it;
    it.nbr_present = present[0];
    it.self_id     = ID_W'(sid);
    it.nbr_id      = ID_W'(nid);
    it.self_x      = sx;
    it.self_y      = sy;
    it.self_radius = RAD_W'(sr);
    it.nbr_x       = nx;
    it.nbr_y       = ny;
    it.nbr_radius  = RAD_W'(nr);
    it.last_nbr    = last[0];
    return it;
  endfunction

  // Mostly neighbours placed near the cell so that admission and overlap are hit.
  function automatic crv_pkg::in_item_t rand_nbr(input bit last);
    crv_pkg::in_item_t it;
    int unsigned       rsum, dxm, dym;
    int                pick;
    it.nbr_present = ($urandom_range(99) >= 4);
    it.self_id     = 16'($urandom);
    it.nbr_id      = ($urandom_range(99) < 5) ? it.self_id : 16'($urandom);
    it.self_x      = $urandom;
    it.self_y      = $urandom;
    pick = $urandom_range(99);
    if (pick < 10) begin
      it.self_radius = 24'($urandom);
      it.nbr_radius  = 24'($urandom);
    end else if (pick < 14) begin
      it.self_radius = '0;
      it.nbr_radius  = '0;
    end else begin
      it.self_radius = 24'($urandom_range(1 << 20));
      it.nbr_radius  = 24'($urandom_range(1 << 20));
    end
    rsum = it.self_radius + it.nbr_radius;
    pick = $urandom_range(99);
    if (pick < 8) begin
      it.nbr_x = $urandom;
      it.nbr_y = $urandom;
    end else begin
      dxm = (pick < 14) ? 0 : $urandom_range((pick < 30) ? 2 * rsum : rsum);
      dym = (pick < 20) ? 0 : $urandom_range(rsum / 2);
      if ($urandom_range(1)) dxm = -dxm;
      if ($urandom_range(1)) dym = -dym;
      it.nbr_x = it.self_x + dxm;
      it.nbr_y = it.self_y + dym;
    end
    it.last_nbr = last;
    return it;
  endfunction

  task automatic queue_runs(input int n_items);
    int queued, run_len;
    queued = 0;
    while (queued < n_items) begin
      run_len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      for (int k = 0; k < run_len; k++) add_pending(rand_nbr(k == run_len - 1));
      queued += run_len;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == crv_pkg::CFG_REST_FACTOR) rf_reg = val[RF_W-1:0];
    else rep_reg = val[REP_W-1:0];
    n_wr++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pend_q.size() != 0 || in_valid || vel_expect_q.size() != 0);
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
  endtask

  // input side: offer queued items, predict on every accepted transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        repel_predict(in_item);
        n_in <= n_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_item  <= pend_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: check every result transfer
  always @(posedge clk) begin : result_check
    crv_pkg::out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_out <= n_out + 1;
        if (vel_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result vel_x %0d count %0d",
                                    $signed(out_item.vel_x), out_item.overlap_count));
        end else begin
          want = vel_expect_q.pop_front();
          if (out_item.vel_x !== want.vel_x)
            report_mismatch($sformatf("result %0d vel_x expected %0d got %0d", n_out,
                                      $signed(want.vel_x), $signed(out_item.vel_x)));
          if (out_item.overlap_count !== want.overlap_count)
            report_mismatch($sformatf("result %0d overlap_count expected %0d got %0d",
                                      n_out, want.overlap_count, out_item.overlap_count));
        end
      end
      out_stall <= hold_off || ($urandom_range(99) < recv_idle);
    end
  end

  initial begin : long_hold
    wait (hold_arm);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : stimulus
    logic [RF_W-1:0]  rf;
    logic [REP_W-1:0] rep;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle = 20;
    recv_idle = 71;
    // no neighbour, same ID, zero dx, no overlap, zero radii
    add_pending(mk_item(0, 5, 6, 0, 0, ONE, ONE / 2, 0, ONE, 1));
    add_pending(mk_item(1, 7, 7, 0, 0, ONE, ONE / 2, 0, ONE, 1));
    add_pending(mk_item(1, 1, 2, 0, 0, ONE, 0, ONE, ONE, 1));
    add_pending(mk_item(1, 1, 2, 0, 0, ONE, 2 * ONE, 0, ONE, 1));
    add_pending(mk_item(1, 1, 2, 100, 200, 0, 100, 200, 0, 1));
    // both signs of dx, admission boundary exactly on and just past the reach
    add_pending(mk_item(1, 1, 2, 0, 0, ONE, ONE / 2, 0, ONE, 0));
    add_pending(mk_item(1, 1, 3, 0, 0, ONE, -ONE, 0, ONE, 0));
    add_pending(mk_item(1, 1, 4, 0, 0, 5 * ONE / 2, 3 * ONE, 4 * ONE, 5 * ONE / 2, 0));
    add_pending(mk_item(1, 1, 5, 0, 0, 5 * ONE / 2, 3 * ONE, 4 * ONE + 1, 5 * ONE / 2, 1));
    // field extremes
    add_pending(mk_item(1, 'hFFFF, 0, 32'sh8000_0000, 32'sh8000_0000,
                        'hFFFFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 'hFFFFFF, 0));
    add_pending(mk_item(1, 0, 'hFFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                        'hFFFFFF, 32'sh7FFF_FFFE, 32'sh8000_0001, 'hFFFFFF, 0));
    add_pending(mk_item(1, 0, 0, 0, 0, ONE, 1, 0, ONE, 0));
    add_pending(mk_item(0, 1, 2, 0, 0, ONE, ONE / 2, 0, ONE, 0));
    add_pending(mk_item(1, 1, 2, 32'sh8000_0000, 0, 'hFFFFFF, 32'sh8000_0001, 0,
                        0, 1));
    add_pending(mk_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    add_pending(mk_item(1, 3, 4, 32'sh7FFF_FFFF, 0, 'hFFFFFF, 32'sh8000_0000, 0,
                        'hFFFFFF, 1));
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin rf = crv_pkg::REST_FACTOR_RST; rep = crv_pkg::REPULSION_RST; end
        1: begin rf = '0; rep = '1; end
        2: begin rf = '1; rep = '1; end
        3: begin rf = RF_W'($urandom_range(2048, 12288)); rep = REP_W'($urandom); end
        4: begin rf = 16'd8192; rep = '0; end
        default: begin rf = RF_W'($urandom); rep = REP_W'($urandom); end
      endcase
      write_reg(crv_pkg::CFG_REST_FACTOR, CFG_W'(rf));
      write_reg(crv_pkg::CFG_REPULSION, rep);
      @(negedge clk);
      send_idle = (ph < 2) ? 20 : (ph < 4) ? 71 : 0;
      recv_idle = (ph < 2) ? 71 : (ph < 4) ? 20 : 0;
      queue_runs(230);
      if (ph == 0) hold_arm = 1'b1;
      wait_drained();
    end

    // one long run at full strength: the overlap count hits its limit
    write_reg(crv_pkg::CFG_REST_FACTOR, CFG_W'(16'hFFFF));
    write_reg(crv_pkg::CFG_REPULSION, '1);
    @(negedge clk);
    send_idle = 0;
    recv_idle = 0;
    for (int k = 0; k < SAT_RUN; k++)
      add_pending(mk_item(1, 1, 2, 0, 0, 'h800000, -1, 0, 'h800000,
                          int'(k == SAT_RUN - 1)));
    wait_drained();

    $display("%0d neighbour transfers in, %0d results checked, %0d register writes, %0d cycles",
             n_in, n_out, n_wr, cycles);
    $display("covered skip cases, admission edges, a long output hold-off and a full count");
    if (errors == 0 && vel_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/crv_pkg.sv
hdl/crv_mul.sv
hdl/cell_repulsion_velocity.sv
verif/tb_cell_repulsion_velocity.sv
